// File: hdl/rgc_pkg.sv
// ----------------------------------------------------------------------------
// rgc_pkg
// Shared types and constants of the grid ray caster.
// ----------------------------------------------------------------------------
package rgc_pkg;

   localparam int NUM_W = 32;
   localparam int DEN_W = 20;
   localparam int ONE_SHIFT = 12;
   localparam logic [DEN_W-1:0] DIST_MAX = 20'hFFFFF;
   localparam logic [11:0] HEIGHT_MAX = 12'hFFF;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST = 1'b1;

   localparam logic CSR_PLAYER_X = 1'b0;
   localparam logic CSR_PLAYER_Y = 1'b1;

   localparam logic [15:0] PLAYER_RESET = 16'd30720;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_STEP,
      ST_LOOK,
      ST_DIST,
      ST_MUL,
      ST_TEXEL,
      ST_HEIGHT,
      ST_RESULT
   } state_type;

endpackage

// File: hdl/grid_ray_caster.sv
// ----------------------------------------------------------------------------
// grid_ray_caster
// DDA ray caster over a square map of two-bit wall codes.
// ----------------------------------------------------------------------------
// After reset the map is cleared one cell per cycle, all MAP_SIZE*MAP_SIZE
// cells, with req_ready low; configuration writes are taken meanwhile. A map
// write item goes from idle straight to the result state. A cast that hits
// takes a setup state, a step and a registered map read per map cell walked,
// and two passes of the shared bit-serial divider (distance, then line height)
// plus the multiply, texel and result states to finish. A finished result
// sits in the output register while the next item is taken.
module grid_ray_caster
   import rgc_pkg::*;
#(
   parameter int MAP_SIZE      = 16,
   parameter int SCREEN_ROWS   = 200,
   parameter int TEXTURE_WIDTH = 32
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [3:0]  req_cell_x,
   input  logic [3:0]  req_cell_y,
   input  logic [1:0]  req_cell_code,
   input  logic [9:0]  req_screen_column,
   input  logic signed [15:0] req_ray_dx,
   input  logic signed [15:0] req_ray_dy,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_column_out,
   output logic        rsp_wall_hit,
   output logic        rsp_hit_side,
   output logic [1:0]  rsp_wall_code,
   output logic [19:0] rsp_wall_distance,
   output logic [4:0]  rsp_tex_col,
   output logic [11:0] rsp_line_height,
   output logic [7:0]  rsp_line_top,
   output logic [7:0]  rsp_line_bottom,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int DEPTH = MAP_SIZE * MAP_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAP_SIZE) + 2;
   localparam int CW    = IW + 14;
   localparam int EW    = 29 + $clog2(2 * MAP_SIZE + 3);
   localparam int HALF  = SCREEN_ROWS / 2;
   localparam logic [NUM_W-1:0] HEIGHT_NUM = NUM_W'(SCREEN_ROWS * 4096);

   state_type state_ff, state_in;

   logic [15:0]          player_x_ff, player_y_ff;
   logic [AW-1:0]        clr_ff;
   logic [1:0]           map_mem [DEPTH];
   logic [1:0]           rdata_ff;
   logic                 mem_we;
   logic [AW-1:0]        waddr, raddr;
   logic [1:0]           wdata;

   logic signed [IW-1:0] mx_ff, my_ff, mx_nx, my_nx;
   logic [EW-1:0]        ex_ff, ey_ff;
   logic                 sxn_ff, syn_ff;
   logic [15:0]          adx_ff, ady_ff;
   logic signed [15:0]   dx_ff, dy_ff;
   logic                 side_ff, hit_ff;
   logic [1:0]           code_ff;
   logic [9:0]           column_ff;
   logic [19:0]          dist_ff;
   logic signed [36:0]   prod_ff;
   logic [4:0]           texel_ff;
   logic [11:0]          height_ff;

   logic                 rsp_valid_ff;
   logic [9:0]           rsp_column_ff;
   logic                 rsp_hit_ff, rsp_side_ff;
   logic [1:0]           rsp_code_ff;
   logic [19:0]          rsp_dist_ff;
   logic [4:0]           rsp_texel_ff;
   logic [11:0]          rsp_height_ff;
   logic [7:0]           rsp_top_ff, rsp_bottom_ff;

   logic                 accept, take_x, off_map, start_out, slot_free;
   logic [3:0]           cx0, cy0;
   logic [12:0]          bx0, by0;
   logic [15:0]          req_adx, req_ady;
   logic signed [CW-1:0] num_s, px_s, py_s, mline, numa;
   logic [11:0]          frac;
   logic [31:0]          texel_prod;
   logic [12:0]          h2, top_v, bot_v;

   logic                 div_start, div_busy, div_done;
   logic [NUM_W-1:0]     div_numer, div_quot;
   logic [DEN_W-1:0]     div_denom;

   rgc_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   function automatic logic [AW-1:0] cell_addr(input int x, input int y);
      return AW'(y * MAP_SIZE + x);
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff <= PLAYER_RESET;
         player_y_ff <= PLAYER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PLAYER_X: player_x_ff <= csr_wdata;
            CSR_PLAYER_Y: player_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cx0       = player_x_ff[15:12];
   assign cy0       = player_y_ff[15:12];
   assign req_adx   = req_ray_dx[15] ? 16'(-req_ray_dx) : 16'(req_ray_dx);
   assign req_ady   = req_ray_dy[15] ? 16'(-req_ray_dy) : 16'(req_ray_dy);

   // walk step
   always_comb begin
      take_x = ex_ff < ey_ff;
      mx_nx  = mx_ff;
      my_nx  = my_ff;
      if (take_x) begin
         mx_nx = sxn_ff ? mx_ff - IW'(1) : mx_ff + IW'(1);
      end else begin
         my_nx = syn_ff ? my_ff - IW'(1) : my_ff + IW'(1);
      end
      off_map = mx_nx[IW-1] || my_nx[IW-1] ||
                mx_nx >= $signed(IW'(MAP_SIZE)) || my_nx >= $signed(IW'(MAP_SIZE));
   end

   always_comb begin
      bx0 = sxn_ff ? {1'b0, player_x_ff[11:0]} : 13'd4096 - {1'b0, player_x_ff[11:0]};
      by0 = syn_ff ? {1'b0, player_y_ff[11:0]} : 13'd4096 - {1'b0, player_y_ff[11:0]};
   end

   // distance numerator from the crossed grid line
   always_comb begin
      px_s = CW'($signed({1'b0, player_x_ff}));
      py_s = CW'($signed({1'b0, player_y_ff}));
      if (!side_ff) begin
         mline = sxn_ff ? (CW'(mx_ff) + CW'(1)) <<< 12 : CW'(mx_ff) <<< 12;
         num_s = mline - px_s;
      end else begin
         mline = syn_ff ? (CW'(my_ff) + CW'(1)) <<< 12 : CW'(my_ff) <<< 12;
         num_s = mline - py_s;
      end
      numa = num_s[CW-1] ? -num_s : num_s;
   end

   always_comb begin
      frac       = (side_ff ? player_x_ff[11:0] : player_y_ff[11:0]) + prod_ff[23:12];
      texel_prod = 32'(frac) * 32'(TEXTURE_WIDTH);
      h2         = 13'(height_ff >> 1);
      top_v      = (h2 > 13'(HALF)) ? 13'd0 : 13'(HALF) - h2;
      bot_v      = (13'(HALF) + h2 > 13'(SCREEN_ROWS - 1)) ? 13'(SCREEN_ROWS - 1)
                                                             : 13'(HALF) + h2;
   end

   // state machine
   always_comb begin
      state_in  = state_ff;
      mem_we    = 1'b0;
      waddr     = clr_ff;
      wdata     = 2'd0;
      raddr     = '0;
      div_start = 1'b0;
      div_numer = NUM_W'(numa[CW-2:0]) << ONE_SHIFT;
      div_denom = DEN_W'(side_ff ? ady_ff : adx_ff);
      start_out = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_WRITE) begin
                  waddr  = cell_addr(int'(req_cell_x), int'(req_cell_y));
                  wdata  = req_cell_code;
                  mem_we = (int'(req_cell_x) < MAP_SIZE) && (int'(req_cell_y) < MAP_SIZE);
                  state_in = ST_RESULT;
               end else if (int'(cx0) >= MAP_SIZE || int'(cy0) >= MAP_SIZE) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: state_in = ST_STEP;
         ST_STEP: begin
            raddr    = cell_addr(int'(mx_nx), int'(my_nx));
            state_in = off_map ? ST_RESULT : ST_LOOK;
         end
         ST_LOOK: begin
            if (rdata_ff != 2'd0) begin
               div_start = 1'b1;
               state_in  = ST_DIST;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_DIST:  if (div_done) state_in = ST_MUL;
         ST_MUL:   state_in = ST_TEXEL;
         ST_TEXEL: begin
            div_start = 1'b1;
            div_numer = HEIGHT_NUM;
            div_denom = dist_ff;
            state_in  = ST_HEIGHT;
         end
         ST_HEIGHT: if (div_done) state_in = ST_RESULT;
         ST_RESULT: begin
            if (slot_free) begin
               start_out = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
   end

   // map memory
   always_ff @(posedge clock) begin
      if (mem_we) map_mem[waddr] <= wdata;
      rdata_ff <= map_mem[raddr];
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               column_ff <= (req_cmd == CMD_CAST) ? req_screen_column : 10'd0;
               hit_ff    <= 1'b0;
               side_ff   <= 1'b0;
               dx_ff     <= req_ray_dx;
               dy_ff     <= req_ray_dy;
               adx_ff    <= req_adx;
               ady_ff    <= req_ady;
               sxn_ff    <= req_ray_dx[15];
               syn_ff    <= req_ray_dy[15];
               mx_ff     <= IW'($signed({1'b0, cx0}));
               my_ff     <= IW'($signed({1'b0, cy0}));
            end
         end
         ST_INIT: begin
            ex_ff <= EW'(bx0) * EW'(ady_ff);
            ey_ff <= EW'(by0) * EW'(adx_ff);
         end
         ST_STEP: begin
            mx_ff   <= mx_nx;
            my_ff   <= my_nx;
            side_ff <= !take_x;
            if (take_x) ex_ff <= ex_ff + (EW'(ady_ff) << ONE_SHIFT);
            else        ey_ff <= ey_ff + (EW'(adx_ff) << ONE_SHIFT);
         end
         ST_LOOK: begin
            code_ff <= rdata_ff;
            if (rdata_ff != 2'd0) hit_ff <= 1'b1;
         end
         ST_DIST: begin
            if (div_done) begin
               dist_ff <= (div_quot > NUM_W'(DIST_MAX)) ? DIST_MAX : div_quot[DEN_W-1:0];
            end
         end
         ST_MUL:   prod_ff  <= $signed({1'b0, dist_ff}) * (side_ff ? dx_ff : dy_ff);
         ST_TEXEL: texel_ff <= texel_prod[16:12];
         ST_HEIGHT: begin
            if (div_done) begin
               height_ff <= (div_quot > NUM_W'(HEIGHT_MAX)) ? HEIGHT_MAX : div_quot[11:0];
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (start_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start_out) begin
         rsp_column_ff <= column_ff;
         rsp_hit_ff    <= hit_ff;
         rsp_side_ff   <= hit_ff && side_ff;
         rsp_code_ff   <= hit_ff ? code_ff : 2'd0;
         rsp_dist_ff   <= hit_ff ? dist_ff : 20'd0;
         rsp_texel_ff  <= hit_ff ? texel_ff : 5'd0;
         rsp_height_ff <= hit_ff ? height_ff : 12'd0;
         rsp_top_ff    <= hit_ff ? top_v[7:0] : 8'd0;
         rsp_bottom_ff <= hit_ff ? bot_v[7:0] : 8'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column_out    = rsp_column_ff;
   assign rsp_wall_hit      = rsp_hit_ff;
   assign rsp_hit_side      = rsp_side_ff;
   assign rsp_wall_code     = rsp_code_ff;
   assign rsp_wall_distance = rsp_dist_ff;
   assign rsp_tex_col       = rsp_texel_ff;
   assign rsp_line_height   = rsp_height_ff;
   assign rsp_line_top      = rsp_top_ff;
   assign rsp_line_bottom   = rsp_bottom_ff;

   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_code_ff != 2'd0)
      else $error("hit reported with empty wall code");
   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_WRITE |=> state_ff == ST_RESULT)
      else $error("write transfer did not go straight to result");
   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("pending result dropped");
   a_div_idle_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP || state_ff == ST_LOOK |-> !div_busy)
      else $error("divider busy during walk");

endmodule

// File: hdl/rgc_divider.sv
// ----------------------------------------------------------------------------
// rgc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgc_divider
   import rgc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] nq_ff, nq_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff;
   logic [DEN_W:0]   shifted, diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, nq_ff[NUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      nq_in   = {nq_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         nq_ff  <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         nq_ff  <= nq_in;
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = nq_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("divider done held");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid ray caster: map writes and ray casts are
// driven over the request channel with random gaps and back-pressure, every
// response is checked field by field against an in-bench DDA predictor.
// ----------------------------------------------------------------------------
module tb_top
   import rgc_pkg::*;
();

   localparam int GRID = 16;
   localparam int ROWS = 200;
   localparam int TEX_W = 32;
   localparam longint UNIT = 4096;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  cell_x;
      logic [3:0]  cell_y;
      logic [1:0]  cell_code;
      logic [9:0]  column;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
   } ray_item_type;

   typedef struct packed {
      logic [9:0]  column;
      logic        hit;
      logic        side;
      logic [1:0]  code;
      logic [19:0] distance;
      logic [4:0]  texel;
      logic [11:0] height;
      logic [7:0]  top;
      logic [7:0]  bottom;
   } ray_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = 1'b0;
   logic [3:0] req_cell_x = '0;
   logic [3:0] req_cell_y = '0;
   logic [1:0] req_cell_code = '0;
   logic [9:0] req_screen_column = '0;
   logic signed [15:0] req_ray_dx = '0;
   logic signed [15:0] req_ray_dy = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [9:0]  rsp_column_out;
   logic        rsp_wall_hit;
   logic        rsp_hit_side;
   logic [1:0]  rsp_wall_code;
   logic [19:0] rsp_wall_distance;
   logic [4:0]  rsp_tex_col;
   logic [11:0] rsp_line_height;
   logic [7:0]  rsp_line_top;
   logic [7:0]  rsp_line_bottom;
   logic csr_we = 1'b0;
   logic csr_index = CSR_PLAYER_X;
   logic [15:0] csr_wdata = '0;

   logic [1:0]  grid_copy [GRID*GRID];
   logic [15:0] pos_x = PLAYER_RESET;
   logic [15:0] pos_y = PLAYER_RESET;
   ray_result_type pending_rays [$];
   int fail_count = 0;
   int casts_sent = 0;
   int writes_sent = 0;
   int hits_seen = 0;
   bit calm = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   grid_ray_caster i_dut (.*);

   always #4 clock = ~clock;

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   function automatic longint floor_q12(longint p);
      if (p >= 0) return p >>> 12;
      return -((-p + 4095) >>> 12);
   endfunction

   // DDA walk over the local map copy; write items update the copy
   function automatic ray_result_type cast_ray(ray_item_type r);
      ray_result_type res;
      longint dx, dy, adx, ady, sx, sy, mx, my, px, py, bx, by;
      longint num, den, wall_dist, hit_pos, height, top, bottom;
      logic [1:0] code;
      bit side;
      res = '0;
      code = 2'd0;
      side = 1'b0;
      if (r.cmd == CMD_WRITE) begin
         grid_copy[r.cell_y * GRID + r.cell_x] = r.cell_code;
         return res;
      end
      res.column = r.column;
      dx = r.dx;
      dy = r.dy;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      sx = dx < 0 ? -1 : 1;
      sy = dy < 0 ? -1 : 1;
      px = pos_x;
      py = pos_y;
      mx = px >>> 12;
      my = py >>> 12;
      if (mx >= GRID || my >= GRID) return res;
      for (int n = 0; n < 2 * GRID + 2; n++) begin
         bx = sx > 0 ? (mx + 1) * UNIT - px : px - mx * UNIT;
         by = sy > 0 ? (my + 1) * UNIT - py : py - my * UNIT;
         if (bx * ady < by * adx) begin
            mx += sx;
            side = 1'b0;
         end else begin
            my += sy;
            side = 1'b1;
         end
         if (mx < 0 || mx >= GRID || my < 0 || my >= GRID) return res;
         code = grid_copy[my * GRID + mx];
         if (code != 0) break;
      end
      if (code == 0) return res;
      if (!side) begin
         num = (sx > 0 ? mx * UNIT : (mx + 1) * UNIT) - px;
         den = adx;
      end else begin
         num = (sy > 0 ? my * UNIT : (my + 1) * UNIT) - py;
         den = ady;
      end
      if (num < 0) num = -num;
      wall_dist = den != 0 ? (num * UNIT) / den : 1048575;
      if (wall_dist > 1048575) wall_dist = 1048575;
      hit_pos = side ? px + floor_q12(wall_dist * dx) : py + floor_q12(wall_dist * dy);
      height = wall_dist != 0 ? (ROWS * UNIT) / wall_dist : 4095;
      if (height > 4095) height = 4095;
      top = ROWS / 2 - height / 2;
      if (top < 0) top = 0;
      bottom = ROWS / 2 + height / 2;
      if (bottom > ROWS - 1) bottom = ROWS - 1;
      res.hit = 1'b1;
      res.side = side;
      res.code = code;
      res.distance = wall_dist[19:0];
      res.texel = 5'(((longint'(hit_pos[11:0]) * TEX_W) >>> 12) & 31);
      res.height = height[11:0];
      res.top = top[7:0];
      res.bottom = bottom[7:0];
      return res;
   endfunction

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 22);
   endfunction

   task automatic send_item(ray_item_type r);
      @(negedge clock);
      if (idle_now()) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_cell_x <= r.cell_x;
      req_cell_y <= r.cell_y;
      req_cell_code <= r.cell_code;
      req_screen_column <= r.column;
      req_ray_dx <= r.dx;
      req_ray_dy <= r.dy;
      do @(posedge clock); while (!req_ready);
      pending_rays.push_back(cast_ray(r));
      if (r.cmd == CMD_CAST) casts_sent++;
      else writes_sent++;
   endtask

   task automatic write_cell(int x, int y, int code);
      ray_item_type r;
      r = '0;
      r.cmd = CMD_WRITE;
      r.cell_x = 4'(x);
      r.cell_y = 4'(y);
      r.cell_code = 2'(code);
      r.column = 10'($urandom);
      r.dx = 16'($urandom);
      r.dy = 16'($urandom);
      send_item(r);
   endtask

   task automatic cast(int dx, int dy);
      ray_item_type r;
      r = '0;
      r.cmd = CMD_CAST;
      r.column = 10'($urandom);
      r.cell_x = 4'($urandom);
      r.cell_y = 4'($urandom);
      r.cell_code = 2'($urandom);
      r.dx = 16'(dx);
      r.dy = 16'(dy);
      send_item(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rays.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_player(logic [15:0] x, logic [15:0] y);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_PLAYER_X;
      csr_wdata <= x;
      @(negedge clock);
      csr_index <= CSR_PLAYER_Y;
      csr_wdata <= y;
      @(negedge clock);
      csr_we <= 1'b0;
      pos_x = x;
      pos_y = y;
   endtask

   task automatic build_border(int code);
      for (int i = 0; i < GRID; i++) begin
         write_cell(i, 0, code);
         write_cell(i, GRID - 1, code);
         write_cell(0, i, code);
         write_cell(GRID - 1, i, code);
      end
   endtask

   task automatic random_cast();
      int pick;
      int dx, dy;
      pick = $urandom_range(19);
      dx = $signed(16'($urandom));
      dy = $signed(16'($urandom));
      if (pick == 0) dx = 0;
      else if (pick == 1) dy = 0;
      else if (pick < 10) begin
         dx = $urandom_range(8192) - 4096;
         dy = $urandom_range(8192) - 4096;
      end
      cast(dx, dy);
   endtask

   task automatic test_empty_map();
      cast(4096, 0);
      cast(0, 0);
      cast(-32768, 32767);
   endtask

   task automatic test_directions();
      build_border(1);
      write_cell(7, 7, 2);
      cast(4096, 0);
      cast(-4096, 0);
      cast(0, 4096);
      cast(0, -4096);
      cast(0, 0);
      cast(2896, 2896);
      cast(-2896, -2896);
      cast(32767, -32768);
      cast(-32768, 1);
      cast(1, 1);
      write_cell(8, 7, 3);
      cast(4096, 0);
      write_cell(8, 7, 0);
   endtask

   task automatic test_player_extremes();
      set_player(16'd0, 16'd0);
      cast(-4096, -4096);
      cast(4096, 4096);
      set_player(16'hFFFF, 16'hFFFF);
      cast(4096, 1);
      cast(-4096, -100);
      set_player(16'h1000, 16'hE000);
      cast(100, -4096);
      cast(0, 0);
   endtask

   task automatic test_random_rays(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 300 == 0) set_player(16'($urandom), 16'($urandom));
         if (i % 300 == 150) set_player(16'($urandom_range(14 * 4096) + 4096),
                                        16'($urandom_range(14 * 4096) + 4096));
         calm = (i % 400) >= 320;
         if ($urandom_range(99) < 25) begin
            if ($urandom_range(9) == 0) write_cell($urandom, $urandom, $urandom);
            else write_cell($urandom_range(14, 1), $urandom_range(14, 1),
                            $urandom_range(3) == 0 ? 0 : $urandom_range(3, 1));
         end else random_cast();
      end
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 20; i++) random_cast();
   endtask

   task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      ray_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rays.size() == 0) begin
            $error("response transfer with nothing outstanding");
            fail_count++;
         end else begin
            want = pending_rays.pop_front();
            if (rsp_wall_hit) hits_seen++;
            check_field("column_out", want.column, rsp_column_out);
            check_field("wall_hit", want.hit, rsp_wall_hit);
            check_field("hit_side", want.side, rsp_hit_side);
            check_field("wall_code", want.code, rsp_wall_code);
            check_field("wall_distance", want.distance, rsp_wall_distance);
            check_field("tex_col", want.texel, rsp_tex_col);
            check_field("line_height", want.height, rsp_line_height);
            check_field("line_top", want.top, rsp_line_top);
            check_field("line_bottom", want.bottom, rsp_line_bottom);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_now();
      end
   end

   initial begin
      int spin;
      foreach (grid_copy[i]) grid_copy[i] = 2'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_map();
      test_directions();
      test_player_extremes();
      test_backpressure();
      test_random_rays(1780);
      wait_idle();
      spin = 0;
      while (pending_rays.size() != 0 && spin < 100000) begin
         @(posedge clock);
         spin++;
      end
      repeat (200) @(posedge clock);
      if (pending_rays.size() != 0) begin
         $error("%0d responses never arrived", pending_rays.size());
         fail_count++;
      end
      $display("Covered %0d map writes and %0d ray casts, %0d of them wall hits,",
               writes_sent, casts_sent, hits_seen);
      $display("across several player positions incl. both corners of the map.");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/rgc_pkg.sv
hdl/rgc_divider.sv
hdl/grid_ray_caster.sv
bench/tb_top.sv
